// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HSFS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define HSFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== hdl/hsfs_pkg.sv =====
// Types, constants and helper functions of the hyperelastic stress block.
package hsfs_pkg;

   typedef logic signed [47:0] word_type;
   typedef logic signed [49:0] wide_type;
   typedef logic [0:0] csr_index_type;

   localparam csr_index_type CSR_BULK  = 1'b0;
   localparam csr_index_type CSR_SHEAR = 1'b1;

   localparam int MUL_LAT = 3;
   localparam int DIV_LAT = 52;

   localparam logic [47:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] NEG_LIM = 48'h8000_0000_0000;
   localparam wide_type SAT_HI = 50'sh0_7FFF_FFFF_FFFF;
   localparam wide_type SAT_LO = 50'sh3_8000_0000_0000;

   // Component order of C and of the cofactors: xx, yy, zz, yz, xz, xy.
   localparam logic [2:0] COF_POS_A [6] = '{3'd1, 3'd0, 3'd0, 3'd5, 3'd5, 3'd4};
   localparam logic [2:0] COF_POS_B [6] = '{3'd2, 3'd2, 3'd1, 3'd4, 3'd3, 3'd3};
   localparam logic [2:0] COF_NEG_A [6] = '{3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd5};
   localparam logic [2:0] COF_NEG_B [6] = '{3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd2};

   function automatic word_type hsfs_sat(input wide_type x);
      word_type r;
      if (x > SAT_HI) begin
         r = $signed(POS_LIM);
      end else if (x < SAT_LO) begin
         r = $signed(NEG_LIM);
      end else begin
         r = x[47:0];
      end
      return r;
   endfunction

   function automatic logic [47:0] hsfs_mag(input word_type x);
      word_type n;
      n = -x;
      return x[47] ? n : x;
   endfunction

   function automatic logic [95:0] hsfs_pp_sum(input logic [47:0] ll, input logic [47:0] lh,
                                                input logic [47:0] hl, input logic [47:0] hh);
      return {hh, 48'd0} + ({48'd0, lh} << 24) + ({48'd0, hl} << 24) + {48'd0, ll};
   endfunction

endpackage

// ===== hdl/hyperelastic_stress_from_strain.sv =====
// Compressible neo-Hookean second Piola stress from Green strain, fully pipelined.
// The block takes one strain pair per cycle while its request side is not stalled;
// most of its depth is the 48-step restoring quotient pipeline that forms
// aux*cof(C)/d, with pipelined multipliers for the cofactors, determinant and aux
// ahead of it. While a result is held on the response side the data pipeline holds
// and the request side is stalled. The user must write the moduli through the
// register port only while no transfer is in flight; the block does not enforce it.
module hyperelastic_stress_from_strain #(
   parameter int FRAC_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  hsfs_pkg::word_type      req_total_xx,
   input  hsfs_pkg::word_type      req_total_yy,
   input  hsfs_pkg::word_type      req_total_zz,
   input  hsfs_pkg::word_type      req_total_yz,
   input  hsfs_pkg::word_type      req_total_xz,
   input  hsfs_pkg::word_type      req_total_xy,
   input  hsfs_pkg::word_type      req_thermal_xx,
   input  hsfs_pkg::word_type      req_thermal_yy,
   input  hsfs_pkg::word_type      req_thermal_zz,
   input  hsfs_pkg::word_type      req_thermal_yz,
   input  hsfs_pkg::word_type      req_thermal_xz,
   input  hsfs_pkg::word_type      req_thermal_xy,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hsfs_pkg::word_type      rsp_stress_xx,
   output hsfs_pkg::word_type      rsp_stress_yy,
   output hsfs_pkg::word_type      rsp_stress_zz,
   output hsfs_pkg::word_type      rsp_stress_yz,
   output hsfs_pkg::word_type      rsp_stress_xz,
   output hsfs_pkg::word_type      rsp_stress_xy,
   output logic                    rsp_singular,
   input  logic                    csr_write,
   input  hsfs_pkg::csr_index_type csr_index,
   input  logic [46:0]             csr_data
);
   import hsfs_pkg::*;

   localparam int PosC   = 1;
   localparam int PosK   = PosC + MUL_LAT + 1;
   localparam int PosD   = PosK + MUL_LAT + 1;
   localparam int PosDm  = PosD + 1;
   localparam int PosAux = PosDm + MUL_LAT + 1;
   localparam int PosQ   = PosAux + DIV_LAT;
   localparam int PosOut = PosQ + 1;

   localparam wide_type OneQ       = 50'sd1 <<< FRAC_BITS;
   localparam word_type TwoThirdsQ = 48'(((64'd2 << FRAC_BITS) + 64'd1) / 64'd3);

   logic        en;
   logic [46:0] bulk_ff, shear_ff;
   wide_type    g_ext;
   logic [PosOut:1] v_ff;

   word_type tot [6];
   word_type thr [6];
   word_type e_in [6];
   word_type c_in [6];

   word_type c_dly_ff [0:PosK-PosC][6];
   word_type k_dly_ff [0:PosAux-PosK][6];
   word_type d_dly_ff [0:PosAux-PosD];
   logic     sing_dly_ff [0:PosQ-PosDm];

   word_type p_pos [6];
   word_type p_neg [6];
   word_type k_in  [6];
   word_type p_det [3];
   word_type q     [6];
   word_type d_in, p_lam, lam_ff, dm_ff, p_aux, aux_ff;
   word_type out_ff [6];
   logic     sing_out_ff;

   assign en        = !(v_ff[PosOut] && rsp_stall);
   assign req_stall = !en;
   assign g_ext     = $signed({3'b000, shear_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         bulk_ff  <= '0;
         shear_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BULK:  bulk_ff  <= csr_data;
            CSR_SHEAR: shear_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[PosOut-1:1], req_valid};
      end
   end

   assign tot[0] = req_total_xx;
   assign tot[1] = req_total_yy;
   assign tot[2] = req_total_zz;
   assign tot[3] = req_total_yz;
   assign tot[4] = req_total_xz;
   assign tot[5] = req_total_xy;
   assign thr[0] = req_thermal_xx;
   assign thr[1] = req_thermal_yy;
   assign thr[2] = req_thermal_zz;
   assign thr[3] = req_thermal_yz;
   assign thr[4] = req_thermal_xz;
   assign thr[5] = req_thermal_xy;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         e_in[i] = hsfs_sat(50'(tot[i]) - 50'(thr[i]));
         c_in[i] = (i < 3) ? hsfs_sat(OneQ + (50'(e_in[i]) <<< 1)) : e_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_dly_ff[0] <= c_in;
         for (int i = 1; i <= PosK - PosC; i++) begin
            c_dly_ff[i] <= c_dly_ff[i-1];
         end
         k_dly_ff[0] <= k_in;
         for (int i = 1; i <= PosAux - PosK; i++) begin
            k_dly_ff[i] <= k_dly_ff[i-1];
         end
         d_dly_ff[0] <= d_in;
         for (int i = 1; i <= PosAux - PosD; i++) begin
            d_dly_ff[i] <= d_dly_ff[i-1];
         end
         sing_dly_ff[0] <= (d_dly_ff[0] == '0);
         for (int i = 1; i <= PosQ - PosDm; i++) begin
            sing_dly_ff[i] <= sing_dly_ff[i-1];
         end
         dm_ff  <= hsfs_sat(50'(d_dly_ff[0]) - OneQ);
         aux_ff <= hsfs_sat(50'(p_aux) - g_ext);
      end
   end

   for (genvar i = 0; i < 6; i++) begin : g_cof
      hsfs_mul #(.SHIFT(FRAC_BITS)) u_pos (
         .clock (clock),
         .en    (en),
         .a     (c_dly_ff[0][COF_POS_A[i]]),
         .b     (c_dly_ff[0][COF_POS_B[i]]),
         .p     (p_pos[i])
      );
      hsfs_mul #(.SHIFT(FRAC_BITS)) u_neg (
         .clock (clock),
         .en    (en),
         .a     (c_dly_ff[0][COF_NEG_A[i]]),
         .b     (c_dly_ff[0][COF_NEG_B[i]]),
         .p     (p_neg[i])
      );
      assign k_in[i] = hsfs_sat(50'(p_pos[i]) - 50'(p_neg[i]));
   end

   // The determinant expands along the first row: xx, xy and xz of C.
   hsfs_mul #(.SHIFT(FRAC_BITS)) u_det_xx (
      .clock (clock), .en (en),
      .a (c_dly_ff[PosK-PosC][0]), .b (k_dly_ff[0][0]), .p (p_det[0])
   );
   hsfs_mul #(.SHIFT(FRAC_BITS)) u_det_xy (
      .clock (clock), .en (en),
      .a (c_dly_ff[PosK-PosC][5]), .b (k_dly_ff[0][5]), .p (p_det[1])
   );
   hsfs_mul #(.SHIFT(FRAC_BITS)) u_det_xz (
      .clock (clock), .en (en),
      .a (c_dly_ff[PosK-PosC][4]), .b (k_dly_ff[0][4]), .p (p_det[2])
   );

   assign d_in = hsfs_sat(50'(p_det[0]) + 50'(p_det[1]) + 50'(p_det[2]));

   hsfs_mul #(.SHIFT(FRAC_BITS)) u_lam (
      .clock (clock), .en (1'b1),
      .a (TwoThirdsQ), .b ($signed({1'b0, shear_ff})), .p (p_lam)
   );

   always_ff @(posedge clock) begin
      lam_ff <= hsfs_sat($signed({3'b000, bulk_ff}) - 50'(p_lam));
   end

   hsfs_mul #(.SHIFT(FRAC_BITS + 1)) u_aux (
      .clock (clock), .en (en),
      .a (lam_ff), .b (dm_ff), .p (p_aux)
   );

   for (genvar i = 0; i < 6; i++) begin : g_div
      hsfs_div u_div (
         .clock (clock),
         .en    (en),
         .a     (aux_ff),
         .b     (k_dly_ff[PosAux-PosK][i]),
         .d     (d_dly_ff[PosAux-PosD]),
         .q     (q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) begin
            if (sing_dly_ff[PosQ-PosDm]) begin
               out_ff[i] <= '0;
            end else if (i < 3) begin
               out_ff[i] <= hsfs_sat(50'(q[i]) + g_ext);
            end else begin
               out_ff[i] <= q[i];
            end
         end
         sing_out_ff <= sing_dly_ff[PosQ-PosDm];
      end
   end

   assign rsp_valid     = v_ff[PosOut];
   assign rsp_stress_xx = out_ff[0];
   assign rsp_stress_yy = out_ff[1];
   assign rsp_stress_zz = out_ff[2];
   assign rsp_stress_yz = out_ff[3];
   assign rsp_stress_xz = out_ff[4];
   assign rsp_stress_xy = out_ff[5];
   assign rsp_singular  = sing_out_ff;

endmodule

// ===== hdl/hsfs_mul.sv =====
// Pipelined signed multiplier with rounding shift and saturation to 48 bits.
module hsfs_mul #(
   parameter int SHIFT = 24
) (
   input  logic              clock,
   input  logic              en,
   input  hsfs_pkg::word_type a,
   input  hsfs_pkg::word_type b,
   output hsfs_pkg::word_type p
);
   import hsfs_pkg::*;

   localparam logic [95:0] Rnd = 96'd1 << (SHIFT - 1);

   logic [47:0] am, bm;
   logic [47:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic        neg_a_ff, neg_b_ff;
   logic [95:0] sum_in, sum_ff, sh;
   logic [47:0] m;
   word_type    p_in, p_ff;

   assign am = hsfs_mag(a);
   assign bm = hsfs_mag(b);

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff    <= am[23:0] * bm[23:0];
         lh_ff    <= am[23:0] * bm[47:24];
         hl_ff    <= am[47:24] * bm[23:0];
         hh_ff    <= am[47:24] * bm[47:24];
         neg_a_ff <= a[47] ^ b[47];
      end
   end

   assign sum_in = hsfs_pp_sum(ll_ff, lh_ff, hl_ff, hh_ff) + Rnd;

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff   <= sum_in;
         neg_b_ff <= neg_a_ff;
      end
   end

   always_comb begin
      sh = sum_ff >> SHIFT;
      if (neg_b_ff) begin
         m = (|sh[95:48] || sh[47:0] > NEG_LIM) ? NEG_LIM : sh[47:0];
      end else begin
         m = (|sh[95:48] || sh[47:0] > POS_LIM) ? POS_LIM : sh[47:0];
      end
      p_in = neg_b_ff ? -$signed(m) : $signed(m);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// ===== hdl/hsfs_div.sv =====
// Pipelined rounded quotient a*b/d with one restoring step per stage.
module hsfs_div (
   input  logic              clock,
   input  logic              en,
   input  hsfs_pkg::word_type a,
   input  hsfs_pkg::word_type b,
   input  hsfs_pkg::word_type d,
   output hsfs_pkg::word_type q
);
   import hsfs_pkg::*;

   localparam int Steps = 48;

   logic [47:0] am, bm;
   logic [47:0] ll_ff, lh_ff, hl_ff, hh_ff, dv0_ff, dv1_ff;
   logic        neg0_ff, neg1_ff;
   logic [95:0] sum_ff;

   logic [47:0] r_ff   [0:Steps];
   logic [47:0] w_ff   [0:Steps];
   logic [47:0] dv_ff  [0:Steps];
   logic        neg_ff [0:Steps];
   logic        ovf_ff [0:Steps];

   logic [48:0] rr2, lim, q49;
   logic [47:0] m;
   word_type    q_in, q_ff;

   assign am = hsfs_mag(a);
   assign bm = hsfs_mag(b);

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff   <= am[23:0] * bm[23:0];
         lh_ff   <= am[23:0] * bm[47:24];
         hl_ff   <= am[47:24] * bm[23:0];
         hh_ff   <= am[47:24] * bm[47:24];
         neg0_ff <= a[47] ^ b[47] ^ d[47];
         dv0_ff  <= hsfs_mag(d);
         sum_ff  <= hsfs_pp_sum(ll_ff, lh_ff, hl_ff, hh_ff);
         neg1_ff <= neg0_ff;
         dv1_ff  <= dv0_ff;
         r_ff[0]   <= sum_ff[95:48];
         w_ff[0]   <= sum_ff[47:0];
         dv_ff[0]  <= dv1_ff;
         neg_ff[0] <= neg1_ff;
         ovf_ff[0] <= sum_ff[95:48] >= dv1_ff;
      end
   end

   for (genvar j = 1; j <= Steps; j++) begin : g_step
      logic [48:0] r2_in, diff_in;
      logic        ge_in;

      assign r2_in   = {r_ff[j-1], w_ff[j-1][47]};
      assign diff_in = r2_in - {1'b0, dv_ff[j-1]};
      assign ge_in   = r2_in >= {1'b0, dv_ff[j-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j]   <= ge_in ? diff_in[47:0] : r2_in[47:0];
            w_ff[j]   <= {w_ff[j-1][46:0], ge_in};
            dv_ff[j]  <= dv_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   always_comb begin
      rr2  = {r_ff[Steps], 1'b0};
      q49  = {1'b0, w_ff[Steps]} + {48'd0, rr2 >= {1'b0, dv_ff[Steps]}};
      lim  = neg_ff[Steps] ? {1'b0, NEG_LIM} : {1'b0, POS_LIM};
      m    = (ovf_ff[Steps] || q49 > lim) ? lim[47:0] : q49[47:0];
      q_in = neg_ff[Steps] ? -$signed(m) : $signed(m);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

// ===== hdl/hsfs_checker.sv =====
// Port-level checks of the hyperelastic stress block and their binding.
`include "assert_macros.svh"

module hsfs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input hsfs_pkg::word_type rsp_stress_xx,
   input hsfs_pkg::word_type rsp_stress_yy,
   input hsfs_pkg::word_type rsp_stress_zz,
   input hsfs_pkg::word_type rsp_stress_yz,
   input hsfs_pkg::word_type rsp_stress_xz,
   input hsfs_pkg::word_type rsp_stress_xy,
   input logic               rsp_singular
);
   import hsfs_pkg::*;

   // A singular result carries zero stress in every component.
   `HSFS_ASSERT_NOW(a_singular_zero, clock, reset, rsp_valid && rsp_singular, rsp_stress_xx == '0 && rsp_stress_yy == '0 && rsp_stress_zz == '0 && rsp_stress_yz == '0 && rsp_stress_xz == '0 && rsp_stress_xy == '0)

   // The request side is only held back by a blocked response transfer.
   `HSFS_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   `HSFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   `HSFS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_stress_xx) && $stable(rsp_stress_xy) && $stable(rsp_singular))

endmodule

bind hyperelastic_stress_from_strain hsfs_checker u_hsfs_checker (.*);

// ===== test/hyperelastic_stress_from_strain_tb.sv =====
// Self-checking testbench of the hyperelastic stress block: random and directed strains.
module hyperelastic_stress_from_strain_tb;
   import hsfs_pkg::*;

   localparam int FRAC = 24;
   localparam longint POS_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint NEG_MIN = -64'sh0000_8000_0000_0000;
   localparam longint ONE_Q = 64'sd1 << FRAC;
   localparam longint TWO_THIRDS_Q = ((64'sd2 << FRAC) + 1) / 3;
   localparam int DRAIN_CYCLES = 100;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      longint s[6];
      bit sing;
   } stress_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   word_type req_total[6];
   word_type req_thermal[6];
   logic rsp_valid;
   logic rsp_stall = 0;
   word_type rsp_stress[6];
   logic rsp_singular;
   logic csr_write = 0;
   csr_index_type csr_index = CSR_BULK;
   logic [46:0] csr_data = '0;

   int error_count = 0;
   longint cycle_count = 0;
   bit rsp_idle_off = 0;
   bit hold_rsp = 0;
   int sent_count = 0;

   // Fixed-point helpers at the block's widths.
   function automatic longint sat48(input logic signed [127:0] x);
      if (x > POS_MAX) return POS_MAX;
      if (x < NEG_MIN) return NEG_MIN;
      return longint'(x);
   endfunction

   function automatic logic signed [127:0] rnd_div(input logic signed [127:0] num,
                                                   input logic signed [127:0] den);
      logic signed [127:0] an, ad, q;
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      q = an / ad;
      if (2 * (an - q * ad) >= ad) q = q + 1;
      return ((num < 0) != (den < 0)) ? -q : q;
   endfunction

   function automatic longint qmul(input longint a, input longint b, input int sh);
      logic signed [127:0] p;
      p = 128'(a) * 128'(b);
      return sat48(rnd_div(p, 128'sd1 <<< sh));
   endfunction

   function automatic longint qmuldiv(input longint a, input longint b, input longint d);
      return sat48(rnd_div(128'(a) * 128'(b), 128'(d)));
   endfunction

   function automatic stress_type compute_stress(input longint tot[6], input longint th[6],
                                                 input longint kk, input longint gg);
      stress_type r;
      longint e[6], c[6], k11, k22, k33, k23, k13, k12, d, lam, dm, aux;
      for (int i = 0; i < 6; i++) e[i] = sat48(128'(tot[i]) - 128'(th[i]));
      for (int i = 0; i < 3; i++) c[i] = sat48(128'(ONE_Q) + 2 * 128'(e[i]));
      for (int i = 3; i < 6; i++) c[i] = e[i];
      k11 = sat48(128'(qmul(c[1], c[2], FRAC)) - qmul(c[3], c[3], FRAC));
      k22 = sat48(128'(qmul(c[0], c[2], FRAC)) - qmul(c[4], c[4], FRAC));
      k33 = sat48(128'(qmul(c[0], c[1], FRAC)) - qmul(c[5], c[5], FRAC));
      k23 = sat48(128'(qmul(c[5], c[4], FRAC)) - qmul(c[0], c[3], FRAC));
      k13 = sat48(128'(qmul(c[5], c[3], FRAC)) - qmul(c[1], c[4], FRAC));
      k12 = sat48(128'(qmul(c[4], c[3], FRAC)) - qmul(c[5], c[2], FRAC));
      d = sat48(128'(qmul(c[0], k11, FRAC)) + qmul(c[5], k12, FRAC) + qmul(c[4], k13, FRAC));
      r.sing = (d == 0);
      for (int i = 0; i < 6; i++) r.s[i] = 0;
      if (!r.sing) begin
         lam = sat48(128'(kk) - qmul(TWO_THIRDS_Q, gg, FRAC));
         dm = sat48(128'(d) - ONE_Q);
         aux = sat48(128'(qmul(lam, dm, FRAC + 1)) - gg);
         r.s[0] = sat48(128'(qmuldiv(aux, k11, d)) + gg);
         r.s[1] = sat48(128'(qmuldiv(aux, k22, d)) + gg);
         r.s[2] = sat48(128'(qmuldiv(aux, k33, d)) + gg);
         r.s[3] = qmuldiv(aux, k23, d);
         r.s[4] = qmuldiv(aux, k13, d);
         r.s[5] = qmuldiv(aux, k12, d);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   class stress_scoreboard;
      stress_type pending[$];
      longint bulk = 0;
      longint shear = 0;

      function void note_strain(input longint tot[6], input longint th[6]);
         pending.push_back(compute_stress(tot, th, bulk, shear));
      endfunction

      task check_stress(input longint got[6], input bit sing);
         stress_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected transfer", 0, 0);
            return;
         end
         want = pending.pop_front();
         for (int i = 0; i < 6; i++)
            if (got[i] != want.s[i]) report_mismatch($sformatf("stress[%0d]", i), got[i], want.s[i]);
         if (sing != want.sing) report_mismatch("singular", sing, want.sing);
      endtask
   endclass

   stress_scoreboard stress_board = new();

   hyperelastic_stress_from_strain i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_total_xx(req_total[0]), .req_total_yy(req_total[1]), .req_total_zz(req_total[2]),
      .req_total_yz(req_total[3]), .req_total_xz(req_total[4]), .req_total_xy(req_total[5]),
      .req_thermal_xx(req_thermal[0]), .req_thermal_yy(req_thermal[1]),
      .req_thermal_zz(req_thermal[2]), .req_thermal_yz(req_thermal[3]),
      .req_thermal_xz(req_thermal[4]), .req_thermal_xy(req_thermal[5]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_stress_xx(rsp_stress[0]), .rsp_stress_yy(rsp_stress[1]),
      .rsp_stress_zz(rsp_stress[2]), .rsp_stress_yz(rsp_stress[3]),
      .rsp_stress_xz(rsp_stress[4]), .rsp_stress_xy(rsp_stress[5]),
      .rsp_singular(rsp_singular),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      for (int i = 0; i < 6; i++) begin
         req_total[i] = '0;
         req_thermal[i] = '0;
      end
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      longint got[6];
      if (!reset && rsp_valid && !rsp_stall) begin
         for (int i = 0; i < 6; i++) got[i] = rsp_stress[i];
         stress_board.check_stress(got, rsp_singular);
      end
   end

   // Receiver stalls in bursts, with a long hold-off when requested.
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1;
            @(posedge clock);
         end else if (!rsp_idle_off && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 0;
            n = $urandom_range(1, 20);
            repeat (n) begin
               @(posedge clock);
               if (hold_rsp) break;
            end
         end
      end
   end

   task automatic write_modulus(input csr_index_type idx, input longint value);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value[46:0];
      @(posedge clock);
      csr_write <= 0;
      if (idx == CSR_BULK) stress_board.bulk = value & POS_MAX;
      else stress_board.shear = value & POS_MAX;
      @(posedge clock);
   endtask

   task automatic send_strain(input longint tot[6], input longint th[6], input bit gaps);
      int n;
      // The block sees only the low 48 bits of each field.
      for (int i = 0; i < 6; i++) begin
         tot[i] = longint'($signed(tot[i][47:0]));
         th[i] = longint'($signed(th[i][47:0]));
      end
      if (gaps && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 15);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      for (int i = 0; i < 6; i++) begin
         req_total[i] <= tot[i][47:0];
         req_thermal[i] <= th[i][47:0];
      end
      do @(posedge clock); while (req_stall);
      stress_board.note_strain(tot, th);
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (stress_board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic longint rand48();
      longint v;
      v = {$urandom(), $urandom()};
      return sat48(128'($signed(v[47:0])));
   endfunction

   // Strain near the identity, with a random scale so some runs reach overflow.
   function automatic longint rand_strain();
      int sh;
      longint v;
      sh = $urandom_range(0, 9) == 0 ? 47 : $urandom_range(8, 27);
      v = rand48();
      return v >>> (47 - sh);
   endfunction

   function automatic longint rand_modulus();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return POS_MAX;
         default: return longint'($urandom_range(0, 1000000)) << $urandom_range(0, 24);
      endcase
   endfunction

   initial begin
      longint tot[6], th[6];
      longint edge_vals[4];
      edge_vals = '{NEG_MIN, POS_MAX, 0, -1};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: moderate moduli with extremes, singular C and overflow, then extreme
      // and zero moduli.
      write_modulus(CSR_BULK, 64'd200 << FRAC);
      write_modulus(CSR_SHEAR, 64'd80 << FRAC);
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 6; i++) begin
            tot[i] = edge_vals[k];
            th[i] = edge_vals[(k + i) % 4];
         end
         send_strain(tot, th, 0);
      end
      for (int i = 0; i < 6; i++) begin
         tot[i] = 0;
         th[i] = 0;
      end
      send_strain(tot, th, 0);
      tot[0] = -(ONE_Q / 2);
      send_strain(tot, th, 0);
      tot[0] = 0;
      tot[5] = ONE_Q;
      send_strain(tot, th, 0);
      tot[5] = 0;
      for (int i = 0; i < 6; i++) tot[i] = ONE_Q / 10 * (i + 1);
      send_strain(tot, th, 0);
      for (int i = 0; i < 6; i++) th[i] = -tot[i];
      send_strain(tot, th, 0);
      wait_drained();
      write_modulus(CSR_BULK, POS_MAX);
      write_modulus(CSR_SHEAR, POS_MAX);
      for (int i = 0; i < 6; i++) begin
         tot[i] = ONE_Q >> 3;
         th[i] = 0;
      end
      send_strain(tot, th, 0);
      tot[0] = POS_MAX;
      send_strain(tot, th, 0);
      wait_drained();
      write_modulus(CSR_BULK, 0);
      write_modulus(CSR_SHEAR, 0);
      send_strain(tot, th, 0);
      wait_drained();

      // Random phases with fresh moduli.
      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 8) rsp_idle_off = 1;
         write_modulus(CSR_BULK, rand_modulus());
         write_modulus(CSR_SHEAR, rand_modulus());
         for (int n = 0; n < 100; n++) begin
            if (ph == 2 && n == 5) begin
               fork
                  begin
                     hold_rsp = 1;
                     repeat (300) @(posedge clock);
                     hold_rsp = 0;
                  end
               join_none
            end
            for (int i = 0; i < 6; i++) begin
               if ($urandom_range(0, 19) == 0) begin
                  tot[i] = rand48();
                  th[i] = rand48();
               end else begin
                  tot[i] = rand_strain();
                  th[i] = rand_strain();
               end
            end
            // Occasionally aim for a singular C: xx strain of exactly minus one half.
            if ($urandom_range(0, 24) == 0) begin
               tot[0] = th[0] - ONE_Q / 2;
               tot[4] = th[4];
               tot[5] = th[5];
            end
            send_strain(tot, th, ph != 8);
         end
         wait_drained();
      end

      $display("Sent %0d strain pairs over twelve modulus settings, extremes included.",
               sent_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/hsfs_pkg.sv
hdl/hsfs_mul.sv
hdl/hsfs_div.sv
hdl/hyperelastic_stress_from_strain.sv
hdl/hsfs_checker.sv
test/hyperelastic_stress_from_strain_tb.sv
